// ===== rtl/packet_duplicate_filter_defines.svh =====
// ----------------------------------------------------------------------------
// Packet duplicate filter assertion macros
// Shared property wrappers for the checker, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_DUPLICATE_FILTER_DEFINES_SVH
`define PACKET_DUPLICATE_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDF_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Packet duplicate filter package
// Depths, widths, verdict codes and sequencer states shared by the modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdf_pkg;

  localparam int HISTORY_DEPTH = 1024;
  localparam int IDX_W         = $clog2(HISTORY_DEPTH);
  localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

  localparam int SEQ_W = 32;
  localparam int LEN_W = 16;
  localparam int FB_W  = 8;

  localparam logic [LEN_W-1:0] MAX_LENGTH_RESET = 16'd1500;
  localparam logic [FB_W-1:0]  VERSION_MASK     = 8'hF0;
  localparam logic [FB_W-1:0]  VERSION_IPV4     = 8'h40;

  typedef enum logic [1:0] {
    VERDICT_FORWARD    = 2'd0,
    VERDICT_BAD_LENGTH = 2'd1,
    VERDICT_NOT_IPV4   = 2'd2,
    VERDICT_DUPLICATE  = 2'd3
  } verdict_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN,
    ST_RECORD
  } state_t;

  typedef struct packed {
    logic bad_len;
    logic not_ipv4;
    logic match;
  } chk_t;

endpackage

`default_nettype wire

// ===== rtl/pdf_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/pdf_check.sv =====
// ----------------------------------------------------------------------------
// Packet duplicate filter check unit
// Length and version checks and the shared sequence number comparator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdf_check import pdf_pkg::*; (
  input  wire logic [SEQ_W-1:0] seq,
  input  wire logic [LEN_W-1:0] pkt_length,
  input  wire logic [FB_W-1:0]  first_byte,
  input  wire logic [LEN_W-1:0] max_length,
  input  wire logic [SEQ_W-1:0] hist_data,
  output      chk_t             chk
);

  always_comb begin
    chk.bad_len  = (pkt_length == '0) || (pkt_length > max_length);
    chk.not_ipv4 = (first_byte & VERSION_MASK) != VERSION_IPV4;
    chk.match    = (hist_data == seq);
  end

endmodule

`default_nettype wire

// ===== rtl/pdf_ctrl.sv =====
// ----------------------------------------------------------------------------
// Packet duplicate filter sequencer
// Captures a descriptor, scans the history one entry a cycle and records it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdf_ctrl import pdf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire logic [SEQ_W-1:0] in_seq,
  input  wire logic [LEN_W-1:0] in_len,
  input  wire logic [FB_W-1:0]  in_fb,
  output      logic [SEQ_W-1:0] item_seq,
  output      logic [LEN_W-1:0] item_len,
  output      logic [FB_W-1:0]  item_fb,
  input  wire chk_t             chk,
  output      logic             ram_we,
  output      logic [IDX_W-1:0] ram_waddr,
  output      logic             ram_re,
  output      logic [IDX_W-1:0] ram_raddr,
  output      logic             res_valid,
  output      verdict_t         res_verdict
);

  state_t           state_r, state_nxt;
  logic [SEQ_W-1:0] seq_r;
  logic [LEN_W-1:0] len_r;
  logic [FB_W-1:0]  fb_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] oldest_r, oldest_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             valid_r, valid_nxt;
  verdict_t         verdict_r, verdict_nxt;
  logic             full;

  assign busy        = (state_r != ST_IDLE);
  assign item_seq    = seq_r;
  assign item_len    = len_r;
  assign item_fb     = fb_r;
  assign res_valid   = valid_r;
  assign res_verdict = verdict_r;
  assign full        = (fill_r == CNT_W'(HISTORY_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      fill_r   <= '0;
      oldest_r <= '0;
      rd_cnt_r <= '0;
      valid_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      oldest_r <= oldest_nxt;
      rd_cnt_r <= rd_cnt_nxt;
      valid_r  <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      seq_r <= in_seq;
      len_r <= in_len;
      fb_r  <= in_fb;
    end
    verdict_r <= verdict_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    fill_nxt    = fill_r;
    oldest_nxt  = oldest_r;
    rd_cnt_nxt  = rd_cnt_r;
    valid_nxt   = 1'b0;
    verdict_nxt = verdict_r;
    ram_we      = 1'b0;
    ram_waddr   = full ? oldest_r : fill_r[IDX_W-1:0];
    ram_re      = 1'b0;
    ram_raddr   = rd_cnt_r[IDX_W-1:0];

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (chk.bad_len) begin
          verdict_nxt = VERDICT_BAD_LENGTH;
          valid_nxt   = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (chk.not_ipv4) begin
          verdict_nxt = VERDICT_NOT_IPV4;
          valid_nxt   = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (fill_r == '0) begin
          state_nxt = ST_RECORD;
        end else begin
          ram_re     = 1'b1;
          ram_raddr  = '0;
          rd_cnt_nxt = CNT_W'(1);
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chk.match) begin
          verdict_nxt = VERDICT_DUPLICATE;
          valid_nxt   = 1'b1;
          state_nxt   = ST_IDLE;
        end else if (rd_cnt_r == fill_r) begin
          state_nxt = ST_RECORD;
        end else begin
          ram_re     = 1'b1;
          rd_cnt_nxt = rd_cnt_r + CNT_W'(1);
        end
      end
      ST_RECORD: begin
        ram_we = 1'b1;
        if (full) begin
          oldest_nxt = (oldest_r == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : oldest_r + IDX_W'(1);
        end else begin
          fill_nxt = fill_r + CNT_W'(1);
        end
        verdict_nxt = VERDICT_FORWARD;
        valid_nxt   = 1'b1;
        state_nxt   = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/packet_duplicate_filter.sv =====
// ----------------------------------------------------------------------------
// Packet duplicate filter
// Drops bad-length and non-IPv4 packets and flags repeated sequence numbers.
// ----------------------------------------------------------------------------
// A descriptor transfer happens on a rising edge with start high and busy low.
// The block then stays busy while it checks length and version, scans the
// history of forwarded sequence numbers one entry per cycle through the read
// port of the history RAM, and records a forwarded number.
// The result strobe follows ST_CHECK for a bad length or a non-IPv4 byte,
// ST_CHECK then ST_RECORD with an empty history, else ST_CHECK, ST_SCAN over
// up to all 1024 entries and, unless a match ends the scan, ST_RECORD. The
// next descriptor may follow in the cycle of the result strobe.
// The result is shown on out_verdict for exactly one cycle with out_valid;
// the receiver cannot stall it. The configuration write channel is always
// ready and must only be used while the block is idle.
// Reset clears the fill count, the replacement pointer and the sequencer, and
// sets max_length to 1500; history contents are not cleared and no clearing
// pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packet_duplicate_filter import pdf_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire logic [SEQ_W-1:0] in_seq_number,
  input  wire logic [LEN_W-1:0] in_pkt_length,
  input  wire logic [FB_W-1:0]  in_first_byte,
  output      logic             out_valid,
  output      logic [1:0]       out_verdict,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [LEN_W-1:0] cfg_data
);

  logic [LEN_W-1:0] max_length_r;
  logic [SEQ_W-1:0] item_seq;
  logic [LEN_W-1:0] item_len;
  logic [FB_W-1:0]  item_fb;
  logic [SEQ_W-1:0] hist_data;
  chk_t             chk;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  verdict_t         res_verdict;

  assign cfg_ready   = 1'b1;
  assign out_verdict = res_verdict;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length_r <= cfg_data;
    end
  end

  pdf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_seq      (in_seq_number),
    .in_len      (in_pkt_length),
    .in_fb       (in_first_byte),
    .item_seq    (item_seq),
    .item_len    (item_len),
    .item_fb     (item_fb),
    .chk         (chk),
    .ram_we      (ram_we),
    .ram_waddr   (ram_waddr),
    .ram_re      (ram_re),
    .ram_raddr   (ram_raddr),
    .res_valid   (out_valid),
    .res_verdict (res_verdict)
  );

  pdf_check u_check (
    .seq        (item_seq),
    .pkt_length (item_len),
    .first_byte (item_fb),
    .max_length (max_length_r),
    .hist_data  (hist_data),
    .chk        (chk)
  );

  pdf_ram #(
    .WIDTH (SEQ_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (item_seq),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (hist_data)
  );

endmodule

`default_nettype wire

// ===== rtl/packet_duplicate_filter_checker.sv =====
// ----------------------------------------------------------------------------
// Packet duplicate filter checker
// Port-level properties on busy, the result strobe, the zero-length verdict and config writes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "packet_duplicate_filter_defines.svh"

module packet_duplicate_filter_checker import pdf_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic [LEN_W-1:0] in_pkt_length,
  input wire logic             out_valid,
  input wire logic [1:0]       out_verdict,
  input wire logic             cfg_valid,
  input wire logic             cfg_ready
);

  logic zero_len_accept;

  assign zero_len_accept = start && !busy && (in_pkt_length == '0);

  `PDF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "Transfer accepted but block not busy")
  `PDF_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "Result strobe longer than one cycle")
  `PDF_ASSERT_SAME(a_strobe_idle, out_valid, !busy, "Result strobe while block is busy")
  `PDF_ASSERT_SAME(a_zero_len, out_valid && $past(zero_len_accept, 2),
                   out_verdict == VERDICT_BAD_LENGTH, "Zero length not reported as bad length")
  `PDF_ASSERT_SAME(a_cfg_idle, cfg_valid && cfg_ready, !busy,
                   "Configuration transfer while a packet is in flight")

endmodule

bind packet_duplicate_filter packet_duplicate_filter_checker u_checker (.*);

`default_nettype wire

// ===== sim/tb_packet_duplicate_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Packet duplicate filter testbench
// Drives packet descriptors and max_length writes from a queue of pending
// transfers, predicts every verdict with its own model of the forwarded
// sequence window, and checks each result strobe against the oldest
// prediction. Directed corner cases come first, then random phases that
// sweep the length limit over its corners and random values.
// ----------------------------------------------------------------------------

module tb_packet_duplicate_filter;
  import pdf_pkg::*;

  typedef enum logic [1:0] {
    OP_PACKET,
    OP_SET_MAX,
    OP_DRAIN
  } stim_kind_t;

  typedef struct {
    stim_kind_t       kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [FB_W-1:0]  fb;
  } stim_op_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [SEQ_W-1:0] in_seq_number = '0;
  logic [LEN_W-1:0] in_pkt_length = '0;
  logic [FB_W-1:0]  in_first_byte = '0;
  logic             out_valid;
  logic [1:0]       out_verdict;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [LEN_W-1:0] cfg_data = '0;

  logic             in_fire = 1'b0;
  logic             cfg_fire = 1'b0;

  stim_op_t         pending_ops[$];
  verdict_t         expected_verdicts[$];
  logic [SEQ_W-1:0] sent_seqs[$];
  int               mismatch_cnt = 0;
  int               pkts_sent = 0;

  logic [LEN_W-1:0] lim_max = MAX_LENGTH_RESET;
  logic [SEQ_W-1:0] fwd_window[HISTORY_DEPTH];
  int               fwd_fill = 0;
  int               fwd_oldest = 0;

  packet_duplicate_filter u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_seq_number (in_seq_number),
    .in_pkt_length (in_pkt_length),
    .in_first_byte (in_first_byte),
    .out_valid     (out_valid),
    .out_verdict   (out_verdict),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic verdict_t filter_verdict(logic [SEQ_W-1:0] seq,
                                              logic [LEN_W-1:0] len,
                                              logic [FB_W-1:0] fb);
    bit hit;
    int i;
    hit = 1'b0;
    if (len == '0 || len > lim_max) return VERDICT_BAD_LENGTH;
    if ((fb & VERSION_MASK) != VERSION_IPV4) return VERDICT_NOT_IPV4;
    for (i = 0; i < fwd_fill; i++) begin
      if (fwd_window[i] == seq) hit = 1'b1;
    end
    if (hit) return VERDICT_DUPLICATE;
    if (fwd_fill < HISTORY_DEPTH) begin
      fwd_window[fwd_fill] = seq;
      fwd_fill++;
    end else begin
      fwd_window[fwd_oldest] = seq;
      fwd_oldest = (fwd_oldest + 1) % HISTORY_DEPTH;
    end
    return VERDICT_FORWARD;
  endfunction

  function automatic bit sender_go();
    return (pkts_sent >= 200 && pkts_sent < 320) || $urandom_range(99) >= 26;
  endfunction

  task automatic flag_error(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("%s", msg);
  endtask

  task automatic add_packet(logic [SEQ_W-1:0] seq, logic [LEN_W-1:0] len,
                            logic [FB_W-1:0] fb);
    stim_op_t op;
    op.kind = OP_PACKET;
    op.seq  = seq;
    op.len  = len;
    op.fb   = fb;
    pending_ops.push_back(op);
    sent_seqs.push_back(seq);
  endtask

  task automatic add_max(logic [LEN_W-1:0] value);
    stim_op_t op;
    op.kind = OP_SET_MAX;
    op.seq  = '0;
    op.len  = value;
    op.fb   = '0;
    pending_ops.push_back(op);
  endtask

  task automatic add_drain();
    stim_op_t op;
    op.kind = OP_DRAIN;
    op.seq  = '0;
    op.len  = '0;
    op.fb   = '0;
    pending_ops.push_back(op);
  endtask

  // Most packets are well formed with fresh numbers so that the window keeps
  // growing; repeats draw on recent and older numbers alike.
  task automatic add_random_packets(int count, logic [LEN_W-1:0] lim);
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [FB_W-1:0]  fb;
    logic [3:0]       nib;
    int               r;
    int               pick;
    int               drain_at;
    drain_at = $urandom_range(count - 1);
    for (int k = 0; k < count; k++) begin
      if (k == drain_at) add_drain();
      r = $urandom_range(99);
      seq = $urandom;
      pick = $urandom_range(2);
      len = (pick == 0) ? 16'd1 : (pick == 1) ? lim : 16'($urandom_range(lim, 1));
      fb = {4'h4, 4'($urandom_range(15))};
      if (r >= 85 && r < 91) begin
        if ($urandom_range(1) == 0 && sent_seqs.size() > 64)
          seq = sent_seqs[sent_seqs.size() - 1 - $urandom_range(63)];
        else
          seq = sent_seqs[$urandom_range(sent_seqs.size() - 1)];
      end else if (r >= 91 && r < 95) begin
        if ($urandom_range(1) == 0 || lim == 16'hFFFF) len = '0;
        else len = 16'($urandom_range(32'hFFFF, 32'(lim) + 1));
        fb = 8'($urandom);
      end else if (r >= 95 && r < 98) begin
        nib = 4'($urandom_range(14));
        if (nib >= 4'd4) nib = nib + 4'd1;
        fb = {nib, 4'($urandom_range(15))};
      end else if (r >= 98) begin
        len = 16'($urandom);
        fb = 8'($urandom);
      end
      add_packet(seq, len, fb);
    end
  endtask

  always @(posedge clk) begin : monitor
    verdict_t want;
    in_fire  <= rst_n && start && !busy;
    cfg_fire <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_verdicts.size() == 0) begin
          flag_error($sformatf("unexpected verdict %0d at %0t", out_verdict, $realtime));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_verdict !== want)
            flag_error($sformatf("verdict error at %0t: expected %0d, got %0d",
                                 $realtime, want, out_verdict));
        end
      end
      if (cfg_valid && cfg_ready) lim_max = cfg_data;
      if (start && !busy)
        expected_verdicts.push_back(filter_verdict(in_seq_number, in_pkt_length,
                                                   in_first_byte));
    end
  end

  always @(negedge clk) begin : driver
    logic     nxt_start;
    logic     nxt_cfg;
    stim_op_t op;
    if (rst_n) begin
      nxt_start = start && !in_fire;
      nxt_cfg   = cfg_valid && !cfg_fire;
      if (!nxt_start && !nxt_cfg && pending_ops.size() != 0) begin
        op = pending_ops[0];
        case (op.kind)
          OP_DRAIN: begin
            if (expected_verdicts.size() == 0) void'(pending_ops.pop_front());
          end
          OP_SET_MAX: begin
            if (expected_verdicts.size() == 0 && sender_go()) begin
              nxt_cfg = 1'b1;
              cfg_data <= op.len;
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            if (sender_go()) begin
              nxt_start = 1'b1;
              in_seq_number <= op.seq;
              in_pkt_length <= op.len;
              in_first_byte <= op.fb;
              pkts_sent++;
              void'(pending_ops.pop_front());
            end
          end
        endcase
      end
      start     <= nxt_start;
      cfg_valid <= nxt_cfg;
    end
  end

  initial begin
    logic [LEN_W-1:0] lim;

    add_packet(32'h0000_0000, 16'd1, 8'h40);
    add_packet(32'h0000_0000, 16'd1500, 8'h45);
    add_packet(32'hFFFF_FFFF, 16'd1500, 8'h4F);
    add_packet(32'h0000_0001, 16'd1501, 8'h40);
    add_packet(32'h0000_0002, 16'd0, 8'h40);
    add_packet(32'h0000_0003, 16'hFFFF, 8'h00);
    add_packet(32'h0000_0004, 16'd100, 8'h00);
    add_packet(32'h0000_0005, 16'd100, 8'hFF);
    add_packet(32'h0000_0006, 16'd100, 8'h3F);
    add_packet(32'hFFFF_FFFF, 16'd1, 8'h40);
    add_packet(32'h0000_0000, 16'd64, 8'h60);
    add_packet(32'h0000_0007, 16'd2000, 8'h40);
    add_packet(32'h0000_0007, 16'd20, 8'h40);
    add_packet(32'hAAAA_AAAA, 16'd20, 8'h60);
    add_max(16'd0);
    add_packet(32'h0000_0008, 16'd1, 8'h40);
    add_packet(32'h0000_0009, 16'd0, 8'h40);
    add_packet(32'h0000_000A, 16'hFFFF, 8'h40);
    add_max(16'hFFFF);
    add_packet(32'h0000_000A, 16'hFFFF, 8'h40);
    add_packet(32'h5555_5555, 16'h8000, 8'h4A);
    add_max(16'd1);
    add_packet(32'h0000_000B, 16'd1, 8'h40);
    add_packet(32'h0000_000C, 16'd2, 8'h40);

    add_max(16'd1500);
    add_random_packets(93, 16'd1500);
    add_max(16'hFFFF);
    add_random_packets(93, 16'hFFFF);
    add_max(16'd1);
    add_random_packets(93, 16'd1);
    lim = 16'($urandom_range(65534, 2));
    add_max(lim);
    add_random_packets(93, lim);
    add_max(16'd1500);
    add_random_packets(93, 16'd1500);
    lim = 16'($urandom_range(65534, 2));
    add_max(lim);
    add_random_packets(93, lim);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (pending_ops.size() != 0 || start || cfg_valid || expected_verdicts.size() != 0);
    repeat (1100) @(posedge clk);

    if (mismatch_cnt == 0) begin
      $display("packet_duplicate_filter: match");
    end else begin
      $display("packet_duplicate_filter: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("packet_duplicate_filter: mismatch");
    $finish;
  end

endmodule
